// ----- rtl/ssdbdf_pkg.sv -----
// ssdbdf_pkg: shared widths and fixed-point helper functions for the
// ssd box decode filter. No dependencies.
package ssdbdf_pkg;

    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_W  = 14;
    localparam int Q_W     = PROD_W - FRAC_W;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 3;
    localparam int DEQ_W   = 22;

    localparam logic [CFG_W-1:0] UNIT_Q14   = 15'd16384;
    localparam logic [15:0]      SIZE_MAX   = 16'hFFFF;
    localparam int               LOG2E_Q14  = 23637;
    localparam int               POLY_A     = 10756;
    localparam int               POLY_B     = 5628;

    typedef enum logic [IDX_W-1:0] {
        REG_SCORE_THR = 3'd0,
        REG_VAR_XY    = 3'd1,
        REG_VAR_WH    = 3'd2,
        REG_OBJ_EXP   = 3'd3,
        REG_CLS_EXP   = 3'd4,
        REG_DELTA_EXP = 3'd5,
        REG_CLS_COUNT = 3'd6,
        REG_MAX_CAND  = 3'd7
    } t_reg_idx;

    // raw int8 scaled by 2^(14+e), exponent clamped to [-15,0]
    function automatic logic signed [DEQ_W-1:0] dequant(logic signed [7:0] raw,
                                                        logic [4:0] e);
        logic signed [4:0]       es;
        logic [3:0]              sh;
        logic signed [DEQ_W-1:0] v;
        es = e;
        if (es > 5'sd0) begin
            es = 5'sd0;
        end
        if (es < -5'sd14) begin
            v = DEQ_W'(raw) >>> 1;
        end else begin
            sh = 4'(es + 5'sd14);
            v = DEQ_W'(raw) <<< sh;
        end
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_unit(logic signed [26:0] v);
        logic [CFG_W-1:0] r;
        if (v < 27'sd0) begin
            r = '0;
        end else if (v > 27'sd16384) begin
            r = UNIT_Q14;
        end else begin
            r = v[CFG_W-1:0];
        end
        return r;
    endfunction

    // size * 2^n * poly / 2^14, saturated to 16 bits
    function automatic logic [15:0] exp_scale(logic [31:0] base, logic signed [9:0] n);
        logic [46:0] ext;
        logic [46:0] r;
        logic [10:0] sh;
        logic [31:0] d;
        logic [15:0] res;
        ext = '0;
        r   = '0;
        sh  = '0;
        d   = '0;
        if (base == 32'd0) begin
            res = '0;
        end else if (n >= 10'sd16) begin
            res = SIZE_MAX;
        end else if (n >= 10'sd0) begin
            ext = {15'd0, base} << n[3:0];
            r   = ext >> FRAC_W;
            res = (r > 47'd65535) ? SIZE_MAX : r[15:0];
        end else begin
            sh  = 11'd14 - 11'(n);
            d   = base >> sh[4:0];
            res = (sh >= 11'd32) ? 16'd0 : d[15:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/ssdbdf_mul.sv -----
// ssdbdf_mul: shared signed multiplier with a registered product.
// Depends on ssdbdf_pkg for operand widths.
module ssdbdf_mul (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [ssdbdf_pkg::MUL_W-1:0]    i_a,
    input  logic signed [ssdbdf_pkg::MUL_W-1:0]    i_b,
    output logic signed [ssdbdf_pkg::PROD_W-1:0]   o_p
);
    import ssdbdf_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/ssd_box_decode_filter.sv -----
// channel | handshake          | payload
// anchor  | i_valid / o_ready  | i_objectness_raw .. i_last_anchor
// result  | o_valid / i_ready  | o_box_x1 .. o_frame_end
// config  | i_cfg_we           | i_cfg_idx, i_cfg_data
// an anchor leaves after the check when dropped on objectness or the cap, after the
// score multiply when dropped on score, and after all 17 multiplies when decoded: these
// share one registered multiplier (issue, then write-back), after one class compare a cycle.
// synchronous active-low reset; no clearing pass. a result waits in the output
// register while the next anchor is taken, a held result stalls only the end.
// Depends on ssdbdf_pkg and ssdbdf_mul.
module ssd_box_decode_filter #(
    parameter int CLASS_LANES = 8,
    parameter int COUNT_LIMIT = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ssdbdf_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [ssdbdf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [7:0]                    i_objectness_raw,
    input  logic [63:0]                          i_class_scores,
    input  logic signed [7:0]                    i_delta_x,
    input  logic signed [7:0]                    i_delta_y,
    input  logic signed [7:0]                    i_delta_w,
    input  logic signed [7:0]                    i_delta_h,
    input  logic [14:0]                          i_anchor_cx,
    input  logic [14:0]                          i_anchor_cy,
    input  logic [15:0]                          i_anchor_w,
    input  logic [15:0]                          i_anchor_h,
    input  logic                                 i_last_anchor,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [14:0]                          o_box_x1,
    output logic [14:0]                          o_box_y1,
    output logic [14:0]                          o_box_x2,
    output logic [14:0]                          o_box_y2,
    output logic [2:0]                           o_class_id,
    output logic [14:0]                          o_score,
    output logic                                 o_is_candidate,
    output logic                                 o_frame_end
);
    import ssdbdf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_ISSUE  = 6'b001000,
        ST_WB     = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        OP_SCORE, OP_DXV, OP_CX, OP_DYV, OP_CY,
        OP_TW, OP_YW, OP_FAW, OP_FFW, OP_FBW, OP_W,
        OP_TH, OP_YH, OP_FAH, OP_FFH, OP_FBH, OP_H
    } t_op;

    // configuration
    logic [14:0] r_thr, r_vxy, r_vwh;
    logic [4:0]  r_obj_e, r_cls_e, r_dlt_e;
    logic [3:0]  r_cls_cnt;
    logic [10:0] r_max_cand;

    // control
    t_state      r_state, n_state;
    t_op         r_op;
    logic [2:0]  r_lane;
    logic [10:0] r_count;
    logic        r_pass;

    // anchor payload
    logic signed [DEQ_W-1:0] r_obj;
    logic [63:0]             r_cls;
    logic signed [7:0]       r_dx, r_dy, r_dw, r_dh;
    logic [14:0]             r_acx, r_acy;
    logic [15:0]             r_aw, r_ah;
    logic                    r_last;

    // working values
    logic signed [DEQ_W-1:0] r_best;
    logic [2:0]              r_best_c;
    logic [14:0]             r_score;
    logic signed [22:0]      r_tmp;
    logic signed [23:0]      r_y;
    logic [13:0]             r_pa;
    logic [13:0]             r_ff;
    logic [12:0]             r_pb;
    logic signed [25:0]      r_cx, r_cy;
    logic [15:0]             r_w, r_h;

    // output register
    logic        r_ovalid;
    logic [14:0] r_x1, r_y1, r_x2, r_y2, r_oscore;
    logic [2:0]  r_ocls;
    logic        r_ocand, r_oend;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [Q_W-1:0]    q;
    logic signed [DEQ_W-1:0]  lane_val, dlt_val;
    logic signed [7:0]        dlt_raw;
    logic [2:0]               last_lane;
    logic [10:0]              cap;
    logic [15:0]              poly;
    logic [13:0]              frac;
    logic                     gate_ok, emit, out_free;

    ssdbdf_mul u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == ST_ISSUE),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign q    = prod[PROD_W-1:FRAC_W];
    assign frac = r_y[13:0];
    assign poly = 16'd16384 + 16'(r_pa) + 16'(r_pb);
    assign cap  = (r_max_cand > 11'(COUNT_LIMIT)) ? 11'(COUNT_LIMIT) : r_max_cand;

    always_comb begin
        if (r_cls_cnt == 4'd0) begin
            last_lane = 3'd0;
        end else if (r_cls_cnt > 4'(CLASS_LANES)) begin
            last_lane = 3'(CLASS_LANES - 1);
        end else begin
            last_lane = 3'(r_cls_cnt - 4'd1);
        end
    end

    assign lane_val = dequant(r_cls[{r_lane, 3'b000} +: 8], r_cls_e);
    assign gate_ok  = (r_obj >= $signed({7'd0, r_thr})) && (r_count < cap);
    assign emit     = r_pass || r_last;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        case (r_op)
            OP_DXV:  dlt_raw = r_dx;
            OP_DYV:  dlt_raw = r_dy;
            OP_TW:   dlt_raw = r_dw;
            default: dlt_raw = r_dh;
        endcase
    end
    assign dlt_val = dequant(dlt_raw, r_dlt_e);

    // operand selection for the shared multiplier
    always_comb begin
        case (r_op)
            OP_SCORE: begin
                mul_a = MUL_W'(r_obj);
                mul_b = MUL_W'(r_best);
            end
            OP_DXV, OP_DYV: begin
                mul_a = MUL_W'(dlt_val);
                mul_b = $signed({10'd0, r_vxy});
            end
            OP_CX, OP_W: begin
                mul_a = (r_op == OP_CX) ? MUL_W'(r_tmp) : $signed({9'd0, poly});
                mul_b = $signed({9'd0, r_aw});
            end
            OP_CY, OP_H: begin
                mul_a = (r_op == OP_CY) ? MUL_W'(r_tmp) : $signed({9'd0, poly});
                mul_b = $signed({9'd0, r_ah});
            end
            OP_TW, OP_TH: begin
                mul_a = MUL_W'(dlt_val);
                mul_b = $signed({10'd0, r_vwh});
            end
            OP_YW, OP_YH: begin
                mul_a = MUL_W'(r_tmp);
                mul_b = MUL_W'(LOG2E_Q14);
            end
            OP_FAW, OP_FAH: begin
                mul_a = $signed({11'd0, frac});
                mul_b = MUL_W'(POLY_A);
            end
            OP_FFW, OP_FFH: begin
                mul_a = $signed({11'd0, frac});
                mul_b = $signed({11'd0, frac});
            end
            OP_FBW, OP_FBH: begin
                mul_a = $signed({11'd0, r_ff});
                mul_b = MUL_W'(POLY_B);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_CHECK;
            ST_CHECK:  n_state = gate_ok ? ST_SCAN : ST_FINISH;
            ST_SCAN:   if (r_lane == last_lane) n_state = ST_ISSUE;
            ST_ISSUE:  n_state = ST_WB;
            ST_WB: begin
                if (r_op == OP_H) begin
                    n_state = ST_FINISH;
                end else if (r_op == OP_SCORE && q < $signed({21'd0, r_thr})) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            ST_FINISH: if (!emit || out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= 15'd8192;
            r_vxy      <= 15'd1638;
            r_vwh      <= 15'd3277;
            r_obj_e    <= 5'b11001;
            r_cls_e    <= 5'b11001;
            r_dlt_e    <= 5'b11001;
            r_cls_cnt  <= 4'd8;
            r_max_cand <= 11'd256;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SCORE_THR: r_thr      <= i_cfg_data;
                REG_VAR_XY:    r_vxy      <= i_cfg_data;
                REG_VAR_WH:    r_vwh      <= i_cfg_data;
                REG_OBJ_EXP:   r_obj_e    <= i_cfg_data[4:0];
                REG_CLS_EXP:   r_cls_e    <= i_cfg_data[4:0];
                REG_DELTA_EXP: r_dlt_e    <= i_cfg_data[4:0];
                REG_CLS_COUNT: r_cls_cnt  <= i_cfg_data[3:0];
                REG_MAX_CAND:  r_max_cand <= i_cfg_data[10:0];
                default:       r_thr      <= r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_SCORE;
            r_lane   <= '0;
            r_count  <= '0;
            r_pass   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FINISH && emit && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_lane <= '0;
                    r_op   <= OP_SCORE;
                    r_pass <= 1'b0;
                end
                ST_SCAN:   r_lane <= r_lane + 3'd1;
                ST_WB: begin
                    if (r_op == OP_SCORE) begin
                        r_pass <= (q >= $signed({21'd0, r_thr}));
                    end
                    if (r_op != OP_H) begin
                        r_op <= t_op'(r_op + 5'd1);
                    end
                end
                ST_FINISH: begin
                    if (!emit || out_free) begin
                        if (r_last) begin
                            r_count <= '0;
                        end else if (r_pass) begin
                            r_count <= r_count + 11'd1;
                        end
                    end
                end
                default: r_lane <= r_lane;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_obj  <= dequant(i_objectness_raw, r_obj_e);
            r_cls  <= i_class_scores;
            r_dx   <= i_delta_x;
            r_dy   <= i_delta_y;
            r_dw   <= i_delta_w;
            r_dh   <= i_delta_h;
            r_acx  <= i_anchor_cx;
            r_acy  <= i_anchor_cy;
            r_aw   <= i_anchor_w;
            r_ah   <= i_anchor_h;
            r_last <= i_last_anchor;
        end
        // first lane always loads, later lanes only on a strictly larger score
        if (r_state == ST_SCAN && (r_lane == 3'd0 || lane_val > r_best)) begin
            r_best   <= lane_val;
            r_best_c <= r_lane;
        end
        if (r_state == ST_WB) begin
            case (r_op)
                OP_SCORE: r_score <= (q > 36'sd32767) ? 15'h7FFF : q[14:0];
                OP_DXV, OP_DYV, OP_TW, OP_TH: r_tmp <= q[22:0];
                OP_CX:    r_cx <= $signed({11'd0, r_acx}) + 26'($signed(q[24:0]));
                OP_CY:    r_cy <= $signed({11'd0, r_acy}) + 26'($signed(q[24:0]));
                OP_YW, OP_YH:   r_y  <= q[23:0];
                OP_FAW, OP_FAH: r_pa <= q[13:0];
                OP_FFW, OP_FFH: r_ff <= q[13:0];
                OP_FBW, OP_FBH: r_pb <= q[12:0];
                OP_W:     r_w <= exp_scale(prod[31:0], r_y[23:14]);
                OP_H:     r_h <= exp_scale(prod[31:0], r_y[23:14]);
                default:  r_pb <= r_pb;
            endcase
        end
        if (r_state == ST_FINISH && emit && out_free) begin
            r_ocand <= r_pass;
            r_oend  <= r_last;
            if (r_pass) begin
                r_x1     <= clamp_unit(27'(r_cx) - $signed({12'd0, r_w[15:1]}));
                r_x2     <= clamp_unit(27'(r_cx) + $signed({12'd0, r_w[15:1]}));
                r_y1     <= clamp_unit(27'(r_cy) - $signed({12'd0, r_h[15:1]}));
                r_y2     <= clamp_unit(27'(r_cy) + $signed({12'd0, r_h[15:1]}));
                r_ocls   <= r_best_c;
                r_oscore <= r_score;
            end else begin
                r_x1     <= '0;
                r_x2     <= '0;
                r_y1     <= '0;
                r_y2     <= '0;
                r_ocls   <= '0;
                r_oscore <= '0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_box_x1       = r_x1;
    assign o_box_y1       = r_y1;
    assign o_box_x2       = r_x2;
    assign o_box_y2       = r_y2;
    assign o_class_id     = r_ocls;
    assign o_score        = r_oscore;
    assign o_is_candidate = r_ocand;
    assign o_frame_end    = r_oend;

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 11'(COUNT_LIMIT))
        else $error("candidate count beyond limit");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_candidate |-> o_box_x1 <= o_box_x2 && o_box_y1 <= o_box_y2)
        else $error("box corners out of order");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_candidate |-> o_frame_end)
        else $error("empty result without frame end");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after anchor transfer");

endmodule

// ----- tb/sv/tb_ssd_box_decode_filter.sv -----
// tb_ssd_box_decode_filter: self-checking bench for the ssd box decode filter,
// with a clocked driver and monitor and a built-in box decode predictor.
// Depends on ssdbdf_pkg and the ssd_box_decode_filter rtl.
module tb_ssd_box_decode_filter;
    import ssdbdf_pkg::*;

    typedef struct {
        logic signed [7:0] obj;
        logic [63:0]       cls;
        logic signed [7:0] dx, dy, dw, dh;
        logic [14:0]       acx, acy;
        logic [15:0]       aw, ah;
        logic              last;
    } t_anchor;

    typedef struct {
        logic [14:0] x1, y1, x2, y2;
        logic [2:0]  cid;
        logic [14:0] score;
        logic        cand, fend;
    } t_box;

    logic        i_clk, i_rst_n, i_cfg_we, i_valid, i_ready, o_ready, o_valid;
    logic [2:0]  i_cfg_idx;
    logic [14:0] i_cfg_data;
    logic signed [7:0] i_objectness_raw, i_delta_x, i_delta_y, i_delta_w, i_delta_h;
    logic [63:0] i_class_scores;
    logic [14:0] i_anchor_cx, i_anchor_cy;
    logic [15:0] i_anchor_w, i_anchor_h;
    logic        i_last_anchor;
    logic [14:0] o_box_x1, o_box_y1, o_box_x2, o_box_y2, o_score;
    logic [2:0]  o_class_id;
    logic        o_is_candidate, o_frame_end;

    ssd_box_decode_filter DUT (.*);

    // predictor copy of the registers and the frame counter
    longint thr_q, vxy_q, vwh_q, cls_n, cap_q, cand_cnt;
    logic [4:0] obj_e, cls_e, dlt_e;

    t_anchor anchor_q[$];
    t_box    boxes_due[$];
    int      errors, boxes_seen, cands_seen, sent;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint deq(logic signed [7:0] raw, logic [4:0] e);
        int es;
        es = $signed(e);
        if (es < -15) es = -15;
        if (es > 0) es = 0;
        if (14 + es < 0) return shr(longint'(raw), 1);
        return longint'(raw) <<< (14 + es);
    endfunction

    function automatic longint unit_clamp(longint v);
        return v < 0 ? 0 : (v > 16384 ? 16384 : v);
    endfunction

    function automatic longint size_exp(longint sz, longint t);
        longint y, n, f, p, b, r;
        y = shr(t * LOG2E_Q14, 14);
        n = shr(y, 14);
        f = y & 16383;
        p = 16384 + shr(f * POLY_A, 14) + shr(shr(f * f, 14) * POLY_B, 14);
        b = sz * p;
        if (b == 0) return 0;
        if (n >= 16) return 65535;
        if (n >= 0) r = (b <<< n) >>> 14;
        else if (14 - n > 62) r = 0;
        else r = shr(b, 14 - n);
        return r > 65535 ? 65535 : r;
    endfunction

    // returns 1 and the box when the anchor yields a result
    function automatic bit decode_anchor(t_anchor a, output t_box r);
        longint o, best, sc, s, lanes, cap, cx, cy, w, h;
        int bc;
        bit acc;
        acc = 0; best = 0; bc = 0; sc = 0;
        r = '{default: '0};
        lanes = cls_n < 1 ? 1 : (cls_n > 8 ? 8 : cls_n);
        cap = cap_q > 1024 ? 1024 : cap_q;
        o = deq(a.obj, obj_e);
        if (o >= thr_q && cand_cnt < cap) begin
            for (int c = 0; c < lanes; c++) begin
                s = deq(a.cls[8*c +: 8], cls_e);
                if (c == 0 || s > best) begin
                    best = s;
                    bc = c;
                end
            end
            sc = shr(o * best, 14);
            if (sc >= thr_q) begin
                cx = a.acx + shr(shr(deq(a.dx, dlt_e) * vxy_q, 14) * a.aw, 14);
                cy = a.acy + shr(shr(deq(a.dy, dlt_e) * vxy_q, 14) * a.ah, 14);
                w = size_exp(a.aw, shr(deq(a.dw, dlt_e) * vwh_q, 14));
                h = size_exp(a.ah, shr(deq(a.dh, dlt_e) * vwh_q, 14));
                r.x1 = 15'(unit_clamp(cx - (w >>> 1)));
                r.y1 = 15'(unit_clamp(cy - (h >>> 1)));
                r.x2 = 15'(unit_clamp(cx + (w >>> 1)));
                r.y2 = 15'(unit_clamp(cy + (h >>> 1)));
                r.cid = 3'(bc);
                r.score = 15'(sc > 32767 ? 32767 : sc);
                r.cand = 1;
                acc = 1;
                cand_cnt = (cand_cnt + 1) & 11'h7FF;
            end
        end
        if (a.last) cand_cnt = 0;
        r.fend = a.last;
        return acc || a.last;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // driver
    int      gap, rd_wait;
    bit      in_took, out_took;
    t_anchor cur;
    always @(negedge i_clk) begin
        t_box r;
        // the channel is free unless an offered anchor still waits for its transfer
        if (i_rst_n && !(i_valid && !in_took)) begin
            if (gap > 0) begin
                gap     <= gap - 1;
                i_valid <= 1'b0;
            end else if (anchor_q.size() > 0) begin
                cur = anchor_q.pop_front();
                if (decode_anchor(cur, r)) boxes_due.push_back(r);
                sent <= sent + 1;
                i_valid          <= 1'b1;
                i_objectness_raw <= cur.obj;
                i_class_scores   <= cur.cls;
                i_delta_x <= cur.dx;  i_delta_y <= cur.dy;
                i_delta_w <= cur.dw;  i_delta_h <= cur.dh;
                i_anchor_cx <= cur.acx;  i_anchor_cy <= cur.acy;
                i_anchor_w  <= cur.aw;   i_anchor_h  <= cur.ah;
                i_last_anchor <= cur.last;
                gap <= int'($urandom_range(0, 3));
            end else begin
                i_valid <= 1'b0;
            end
        end
        // receiver idles a drawn number of cycles after each result transfer
        if (out_took) rd_wait = int'($urandom_range(0, 3));
        else if (rd_wait > 0) rd_wait = rd_wait - 1;
        i_ready <= (rd_wait == 0);
    end

    // monitor
    always @(posedge i_clk) begin
        t_box e;
        in_took  <= i_rst_n && i_valid && o_ready;
        out_took <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            boxes_seen++;
            if (boxes_due.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
            end else begin
                e = boxes_due.pop_front();
                if (o_is_candidate) cands_seen++;
                if ({o_box_x1, o_box_y1, o_box_x2, o_box_y2, o_class_id, o_score,
                     o_is_candidate, o_frame_end} !==
                    {e.x1, e.y1, e.x2, e.y2, e.cid, e.score, e.cand, e.fend}) begin
                    $display("%0t: mismatch exp %0d %0d %0d %0d c%0d s%0d %b%b", $time,
                             e.x1, e.y1, e.x2, e.y2, e.cid, e.score, e.cand, e.fend);
                    $display("%0t:          got %0d %0d %0d %0d c%0d s%0d %b%b", $time,
                             o_box_x1, o_box_y1, o_box_x2, o_box_y2, o_class_id,
                             o_score, o_is_candidate, o_frame_end);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [14:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SCORE_THR: thr_q = longint'(val);
            REG_VAR_XY:    vxy_q = longint'(val);
            REG_VAR_WH:    vwh_q = longint'(val);
            REG_OBJ_EXP:   obj_e = val[4:0];
            REG_CLS_EXP:   cls_e = val[4:0];
            REG_DELTA_EXP: dlt_e = val[4:0];
            REG_CLS_COUNT: cls_n = longint'(val[3:0]);
            default:       cap_q = longint'(val[10:0]);
        endcase
    endtask

    // wait until the block has delivered everything and finished the last anchor
    task automatic drain();
        wait (anchor_q.size() == 0 && !i_valid && boxes_due.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_anchor rand_anchor(bit mostly_kept);
        t_anchor a;
        a.obj = mostly_kept && $urandom_range(0, 3) != 0 ? 8'($urandom_range(60, 127))
                                                          : 8'($urandom);
        a.cls = {$urandom, $urandom};
        if (mostly_kept && $urandom_range(0, 2) != 0)
            a.cls[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(90, 127));
        a.dx = 8'($urandom); a.dy = 8'($urandom);
        a.dw = 8'($urandom); a.dh = 8'($urandom);
        a.acx = 15'($urandom_range(0, 16384)); a.acy = 15'($urandom_range(0, 16384));
        a.aw = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000));
        a.ah = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000));
        a.last = $urandom_range(0, 14) == 0;
        return a;
    endfunction

    initial begin
        t_anchor a;
        int ph;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = REG_SCORE_THR; i_cfg_data = '0;
        i_valid = 0; i_ready = 0; gap = 0; rd_wait = 0; errors = 0; sent = 0;
        boxes_seen = 0; cands_seen = 0;
        {i_objectness_raw, i_class_scores, i_delta_x, i_delta_y, i_delta_w, i_delta_h,
         i_anchor_cx, i_anchor_cy, i_anchor_w, i_anchor_h, i_last_anchor} = '0;
        thr_q = 8192; vxy_q = 1638; vwh_q = 3277;
        obj_e = 5'h19; cls_e = 5'h19; dlt_e = 5'h19;
        cls_n = 8; cap_q = 256; cand_cnt = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, class ties and the frame end
        a = '{obj: 127, cls: {8{8'sd127}}, dx: 127, dy: -128, dw: 127, dh: -128,
              acx: 16384, acy: 0, aw: 16'hFFFF, ah: 0, last: 0};
        anchor_q.push_back(a);
        a.dx = -128; a.dy = 127; a.dw = -128; a.dh = 127; a.acx = 0; a.acy = 16384;
        a.aw = 0; a.ah = 16'hFFFF; a.cls = 64'h0102_7F7F_0000_0080;
        anchor_q.push_back(a);
        a.obj = -128; anchor_q.push_back(a);
        a.obj = 63; anchor_q.push_back(a);
        a.obj = 64; a.cls = 64'h8080_8080_8080_8080; anchor_q.push_back(a);
        a.obj = 127; a.cls = 64'h7F00_0000_0000_0040; a.aw = 8000; a.ah = 8000;
        anchor_q.push_back(a);
        a.last = 1; anchor_q.push_back(a);
        a.obj = 0; anchor_q.push_back(a);
        drain();

        // configuration phases: defaults first, then extremes and random points
        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                1: begin
                    write_reg(REG_SCORE_THR, 0); write_reg(REG_VAR_XY, 16384);
                    write_reg(REG_VAR_WH, 16384); write_reg(REG_OBJ_EXP, 0);
                    write_reg(REG_CLS_EXP, 0); write_reg(REG_DELTA_EXP, 0);
                    write_reg(REG_CLS_COUNT, 1); write_reg(REG_MAX_CAND, 3);
                end
                2: begin
                    write_reg(REG_SCORE_THR, 16384); write_reg(REG_VAR_XY, 0);
                    write_reg(REG_VAR_WH, 0); write_reg(REG_OBJ_EXP, 5'h11);
                    write_reg(REG_CLS_EXP, 5'h11); write_reg(REG_DELTA_EXP, 5'h11);
                    write_reg(REG_CLS_COUNT, 0); write_reg(REG_MAX_CAND, 0);
                end
                3: begin
                    // out-of-range exponents and class count, cap above the limit
                    write_reg(REG_SCORE_THR, 100); write_reg(REG_OBJ_EXP, 5'h10);
                    write_reg(REG_CLS_EXP, 5'h05); write_reg(REG_DELTA_EXP, 5'h1F);
                    write_reg(REG_CLS_COUNT, 15); write_reg(REG_MAX_CAND, 2047);
                end
                4: begin
                    write_reg(REG_SCORE_THR, 2000); write_reg(REG_OBJ_EXP, 5'h19);
                    write_reg(REG_CLS_EXP, 5'h19); write_reg(REG_DELTA_EXP, 5'h18);
                    write_reg(REG_CLS_COUNT, 8); write_reg(REG_MAX_CAND, 1024);
                    write_reg(REG_VAR_XY, 16384); write_reg(REG_VAR_WH, 16384);
                end
                default: if (ph > 4) begin
                    write_reg(REG_SCORE_THR, 15'($urandom_range(0, 12000)));
                    write_reg(REG_VAR_XY, 15'($urandom_range(0, 16384)));
                    write_reg(REG_VAR_WH, 15'($urandom_range(0, 16384)));
                    write_reg(REG_OBJ_EXP, 15'($urandom_range(0, 31)));
                    write_reg(REG_CLS_EXP, 15'($urandom_range(0, 31)));
                    write_reg(REG_DELTA_EXP, 15'($urandom_range(0, 31)));
                    write_reg(REG_CLS_COUNT, 15'($urandom_range(0, 9)));
                    write_reg(REG_MAX_CAND, 15'($urandom_range(1, 12)));
                end
            endcase
            for (int k = 0; k < 95; k++) anchor_q.push_back(rand_anchor(ph != 2));
            a = rand_anchor(1); a.last = 1; anchor_q.push_back(a);
            drain();
        end

        $display("%0d anchors sent, %0d results checked, %0d of them candidates",
                 sent, boxes_seen, cands_seen);
        $display("covered ten register settings incl. extremes, caps and frame ends");
        if (errors == 0 && boxes_due.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/ssdbdf_pkg.sv
rtl/ssdbdf_mul.sv
rtl/ssd_box_decode_filter.sv
tb/sv/tb_ssd_box_decode_filter.sv
